// ===== rtl/core/mva_pkg.sv =====
// shared types, constants and arithmetic helpers of the molecular virial accumulator
package mva_pkg;

  localparam int unsigned FracBits = 32;
  localparam int unsigned WordW = 64;
  localparam int unsigned MassW = 63;
  localparam int unsigned ProdW = 128;

  localparam logic [1:0] KindAtom   = 2'd0;
  localparam logic [1:0] KindLoad   = 2'd1;
  localparam logic [1:0] KindFinish = 2'd2;

  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMin = 64'h8000_0000_0000_0000;

  // accumulator slot order xx, yy, zz, xy, xz, yz
  typedef enum logic [2:0] {
    SlotXx = 3'd0, SlotYy = 3'd1, SlotZz = 3'd2,
    SlotXy = 3'd3, SlotXz = 3'd4, SlotYz = 3'd5
  } slot_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone     = 4'd0,
    OpLatch    = 4'd1,  // capture the request operands
    OpMul      = 4'd2,  // one product (or one half of a cross pair) for a slot into the product register
    OpAtomAcc  = 4'd3,  // subtract scaled product from a partial
    OpSumAcc   = 4'd4,  // gradient and weighted position sums for one axis
    OpDivStart = 4'd5,  // start the divider on the product register
    OpCorrAcc  = 4'd6,  // add the quotient to a partial
    OpFold     = 4'd7,  // fold all partials into totals and clear per-molecule state
    OpLoadBase = 4'd8,
    OpEmit     = 4'd9,  // place one tensor entry in the output register
    OpClrTot   = 4'd10,
    OpMassMul  = 4'd11  // mass times position for one axis
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] slot;
    logic [1:0] axis;
    logic [3:0] entry;
    logic       corr;    // products use the running sums rather than the atom
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic eom;
    logic mass_zero;
    logic [1:0] kind;
    logic idx_ok;
  } stat_t;

  // row-major entry to slot
  function automatic logic [2:0] entry_slot(input logic [3:0] e);
    logic [2:0] s;
    case (e)
      4'd0: s = 3'(SlotXx);
      4'd1: s = 3'(SlotXy);
      4'd2: s = 3'(SlotXz);
      4'd3: s = 3'(SlotXy);
      4'd4: s = 3'(SlotYy);
      4'd5: s = 3'(SlotYz);
      4'd6: s = 3'(SlotXz);
      4'd7: s = 3'(SlotYz);
      default: s = 3'(SlotZz);
    endcase
    return s;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) return a[63] ? SMin : SMax;
    return s;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) return a[63] ? SMin : SMax;
    return s;
  endfunction

  // sign and 128-bit magnitude to saturated 64-bit word
  function automatic logic [63:0] sat_mag(input logic neg, input logic [127:0] m);
    if (neg) begin
      if (m[127:64] != '0 || m[63:0] > SMin) return SMin;
      return ~m[63:0] + 64'd1;
    end
    if (m[127:64] != '0 || m[63:0] > SMax) return SMax;
    return m[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

// ===== rtl/core/mva_mul.sv =====
// 64x64 unsigned multiplier built from 32x32 partial products accumulated in turn
module mva_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);
  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   step_q;
  logic         busy_q;
  logic [31:0]  ma, mb;
  logic [63:0]  pp;

  always_comb begin
    ma = step_q[1] ? a_q[63:32] : a_q[31:0];
    mb = step_q[0] ? b_q[63:32] : b_q[31:0];
    pp = 64'(ma) * 64'(mb);
    acc_d = acc_q + (128'(pp) << (7'(step_q[1]) * 7'd32 + 7'(step_q[0]) * 7'd32));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign p_o = acc_q;
endmodule

// ===== rtl/core/mva_div.sv =====
// restoring 128 by 64 divider, one quotient bit a cycle
module mva_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         busy_o,
  output logic [127:0] quo_o
);
  logic [127:0] q_q;
  logic [63:0]  r_q, d_q;
  logic [6:0]   cnt_q;
  logic         busy_q;
  logic [64:0]  r_sh;
  logic         take;

  always_comb begin
    r_sh = {r_q, q_q[127]};
    take = r_sh >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'd127) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      r_q <= take ? 64'(r_sh - {1'b0, d_q}) : r_sh[63:0];
      q_q <= {q_q[126:0], take};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = q_q;
endmodule

// ===== rtl/core/mva_datapath.sv =====
// datapath: operand latches, state registers, shared multiplier and divider
module mva_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mva_pkg::cmd_t       cmd_i,
  output mva_pkg::stat_t      stat_o,
  output logic                mul_done_o,
  input  logic [1:0]          kind_i,
  input  logic signed [63:0]  grad_x_i,
  input  logic signed [63:0]  grad_y_i,
  input  logic signed [63:0]  grad_z_i,
  input  logic signed [63:0]  pos_x_i,
  input  logic signed [63:0]  pos_y_i,
  input  logic signed [63:0]  pos_z_i,
  input  logic [62:0]         atom_mass_i,
  input  logic [62:0]         mol_mass_i,
  input  logic                end_of_molecule_i,
  input  logic [3:0]          vir_index_i,
  input  logic signed [63:0]  vir_value_i,
  output logic [3:0]          tensor_index_o,
  output logic signed [63:0]  virial_value_o,
  output logic                last_o
);
  logic [63:0] g_q [3];
  logic [63:0] p_q [3];
  logic [62:0] am_q, mm_q;
  logic        eom_q, idx_ok_q;
  logic [1:0]  kind_q;
  logic [3:0]  vidx_q;
  logic [63:0] vval_q;

  logic [63:0] part_q [6];
  logic [63:0] gs_q [3];
  logic [63:0] ws_q [3];
  logic [63:0] tot_q [6];
  logic [63:0] base_q [9];

  // signed product register (sum of up to two products)
  logic         pneg_q;
  logic [127:0] pmag_q;
  logic         second_q;   // second cross product in flight
  logic         mstart;
  logic [63:0]  ma, mb;
  logic         mdone;
  logic [127:0] mprod;
  logic         cur_neg_q;
  logic [63:0]  xa, xb;
  logic [1:0]   ia, ib;
  logic         nneg;
  logic [127:0] nmag;
  logic         dstart, dbusy;
  logic [127:0] quo;
  logic [63:0]  scaled;
  logic [2:0]   slot;
  logic [63:0]  vec_a [3];
  logic [63:0]  vec_b [3];

  assign slot = cmd_i.slot;

  // operand pair for the slot: diagonal a[i]*b[i]; cross a[i]*b[j] then a[j]*b[i]
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_a[k] = cmd_i.corr ? gs_q[k] : g_q[k];
      vec_b[k] = cmd_i.corr ? ws_q[k] : p_q[k];
    end
    case (slot)
      3'd0: begin ia = 2'd0; ib = 2'd0; end
      3'd1: begin ia = 2'd1; ib = 2'd1; end
      3'd2: begin ia = 2'd2; ib = 2'd2; end
      3'd3: begin ia = second_q ? 2'd1 : 2'd0; ib = second_q ? 2'd0 : 2'd1; end
      3'd4: begin ia = second_q ? 2'd2 : 2'd0; ib = second_q ? 2'd0 : 2'd2; end
      default: begin ia = second_q ? 2'd2 : 2'd1; ib = second_q ? 2'd1 : 2'd2; end
    endcase
    if (cmd_i.op == mva_pkg::OpMassMul) begin
      xa = {1'b0, am_q};
      xb = p_q[cmd_i.axis];
    end else begin
      xa = vec_a[ia];
      xb = vec_b[ib];
    end
    ma = mva_pkg::mag64(xa);
    mb = mva_pkg::mag64(xb);
  end

  assign mstart = (cmd_i.op == mva_pkg::OpMul) || (cmd_i.op == mva_pkg::OpMassMul);

  mva_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .done_o(mdone), .p_o(mprod)
  );

  // signed magnitude add of the new product into the product register
  always_comb begin
    if (!second_q) begin
      nneg = cur_neg_q;
      nmag = mprod;
    end else if (pneg_q == cur_neg_q) begin
      nneg = pneg_q;
      nmag = pmag_q + mprod;
    end else if (pmag_q >= mprod) begin
      nneg = pneg_q;
      nmag = pmag_q - mprod;
    end else begin
      nneg = cur_neg_q;
      nmag = mprod - pmag_q;
    end
  end

  // scaling: shift by fraction bits, one more for cross slots in the atom accumulate; the correction uses the quotient
  always_comb begin
    if (cmd_i.op == mva_pkg::OpCorrAcc)
      scaled = mva_pkg::sat_mag(pneg_q, quo);
    else if (slot >= 3'd3 && cmd_i.op == mva_pkg::OpAtomAcc)
      scaled = mva_pkg::sat_mag(pneg_q, pmag_q >> (mva_pkg::FracBits + 1));
    else
      scaled = mva_pkg::sat_mag(pneg_q, pmag_q >> mva_pkg::FracBits);
  end

  assign dstart = cmd_i.op == mva_pkg::OpDivStart;

  mva_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(pmag_q),
    .den_i((slot >= 3'd3) ? {mm_q, 1'b0} : {1'b0, mm_q}),
    .busy_o(dbusy), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        part_q[k] <= '0;
        tot_q[k]  <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        gs_q[k] <= '0;
        ws_q[k] <= '0;
      end
      for (int k = 0; k < 9; k++) base_q[k] <= '0;
      cur_neg_q <= 1'b0;
      pneg_q    <= 1'b0;
    end else begin
      if (mstart) cur_neg_q <= xa[63] ^ xb[63];
      if (mdone) begin
        pneg_q <= nneg;
        second_q <= (slot >= 3'd3) && !second_q && (cmd_i.op != mva_pkg::OpMassMul);
      end
      unique case (cmd_i.op)
        mva_pkg::OpAtomAcc: part_q[slot] <= mva_pkg::sat_sub(part_q[slot], scaled);
        mva_pkg::OpCorrAcc: part_q[slot] <= mva_pkg::sat_add(part_q[slot], scaled);
        mva_pkg::OpSumAcc: begin
          gs_q[cmd_i.axis] <= mva_pkg::sat_add(gs_q[cmd_i.axis], g_q[cmd_i.axis]);
          ws_q[cmd_i.axis] <= mva_pkg::sat_add(ws_q[cmd_i.axis], scaled);
        end
        mva_pkg::OpFold: begin
          for (int k = 0; k < 6; k++) begin
            tot_q[k]  <= mva_pkg::sat_add(tot_q[k], part_q[k]);
            part_q[k] <= '0;
          end
          for (int k = 0; k < 3; k++) begin
            gs_q[k] <= '0;
            ws_q[k] <= '0;
          end
        end
        mva_pkg::OpLoadBase: base_q[vidx_q] <= vval_q;
        mva_pkg::OpClrTot: for (int k = 0; k < 6; k++) tot_q[k] <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mdone) pmag_q <= nmag;
    if (cmd_i.op == mva_pkg::OpLatch) begin
      g_q[0] <= grad_x_i; g_q[1] <= grad_y_i; g_q[2] <= grad_z_i;
      p_q[0] <= pos_x_i;  p_q[1] <= pos_y_i;  p_q[2] <= pos_z_i;
      am_q <= atom_mass_i;
      mm_q <= mol_mass_i;
      eom_q <= end_of_molecule_i;
      kind_q <= kind_i;
      idx_ok_q <= vir_index_i < 4'd9;
      vidx_q <= vir_index_i;
      vval_q <= vir_value_i;
    end
    if (cmd_i.op == mva_pkg::OpEmit) begin
      tensor_index_o <= cmd_i.entry;
      virial_value_o <= mva_pkg::sat_add(tot_q[mva_pkg::entry_slot(cmd_i.entry)],
                                         base_q[cmd_i.entry]);
      last_o <= cmd_i.entry == 4'd8;
    end
  end

  assign mul_done_o = mdone;
  assign stat_o = '{div_busy: dbusy, eom: eom_q, mass_zero: (mm_q == '0),
                    kind: kind_q, idx_ok: idx_ok_q};
endmodule

// ===== rtl/core/mva_ctrl.sv =====
// controller: sequences multiplies, accumulates, correction divides and emission
module mva_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  mva_pkg::stat_t stat_i,
  input  logic           mul_done_i,
  output mva_pkg::cmd_t  cmd_o
);
  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StDecode = 11'b00000000010,
    StMul    = 11'b00000000100,
    StMulW   = 11'b00000001000,
    StAcc    = 11'b00000010000,
    StMass   = 11'b00000100000,
    StMassW  = 11'b00001000000,
    StDivW   = 11'b00010000000,
    StFold   = 11'b00100000000,
    StEmit   = 11'b01000000000,
    StOut    = 11'b10000000000
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  slot_q, slot_d;
  logic [1:0]  axis_q, axis_d;
  logic [3:0]  entry_q, entry_d;
  logic        corr_q, corr_d;
  logic        sec_q, sec_d;     // waiting for the second cross product
  logic        divst_q, divst_d; // divider already launched for the slot

  always_comb begin
    state_d = state_q; slot_d = slot_q; axis_d = axis_q; entry_d = entry_q;
    corr_d = corr_q; sec_d = sec_q; divst_d = divst_q;
    cmd_o = '{op: mva_pkg::OpNone, slot: slot_q, axis: axis_q, entry: entry_q, corr: corr_q};
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = mva_pkg::OpLatch;
          state_d = StDecode;
        end
      end
      StDecode: begin
        slot_d = 3'd0; axis_d = 2'd0; entry_d = 4'd0; corr_d = 1'b0; sec_d = 1'b0;
        divst_d = 1'b0;
        case (stat_i.kind)
          mva_pkg::KindAtom: state_d = StMul;
          mva_pkg::KindLoad: begin
            if (stat_i.idx_ok) cmd_o.op = mva_pkg::OpLoadBase;
            state_d = StIdle;
          end
          mva_pkg::KindFinish: state_d = StEmit;
          default: state_d = StIdle;
        endcase
      end
      StMul: begin
        cmd_o.op = mva_pkg::OpMul;
        state_d = StMulW;
      end
      StMulW: begin
        if (mul_done_i) begin
          if (slot_q >= 3'd3 && !sec_q) begin
            sec_d = 1'b1;
            state_d = StMul;
          end else begin
            sec_d = 1'b0;
            state_d = corr_q ? StDivW : StAcc;
          end
        end
      end
      StAcc: begin
        cmd_o.op = mva_pkg::OpAtomAcc;
        if (slot_q == 3'd5) begin
          slot_d = 3'd0;
          state_d = StMass;
        end else begin
          slot_d = slot_q + 3'd1;
          state_d = StMul;
        end
      end
      StMass: begin
        cmd_o.op = mva_pkg::OpMassMul;
        state_d = StMassW;
      end
      StMassW: begin
        if (mul_done_i) state_d = StFold;
      end
      StDivW: begin
        if (!divst_q) begin
          cmd_o.op = mva_pkg::OpDivStart;
          divst_d = 1'b1;
        end else if (!stat_i.div_busy) begin
          cmd_o.op = mva_pkg::OpCorrAcc;
          divst_d = 1'b0;
          if (slot_q == 3'd5) begin
            state_d = StFold;
            slot_d = 3'd0;
            corr_d = 1'b0;
            axis_d = 2'd3;
          end else begin
            slot_d = slot_q + 3'd1;
            state_d = StMul;
          end
        end
      end
      StFold: begin
        if (!corr_q && axis_q != 2'd3) begin
          // sum accumulation for one axis after its mass product
          cmd_o.op = mva_pkg::OpSumAcc;
          if (axis_q == 2'd2) begin
            if (!stat_i.eom) state_d = StIdle;
            else if (stat_i.mass_zero) begin
              axis_d = 2'd3;
            end else begin
              corr_d = 1'b1;
              slot_d = 3'd0;
              state_d = StMul;
            end
          end else begin
            axis_d = axis_q + 2'd1;
            state_d = StMass;
          end
        end else begin
          cmd_o.op = mva_pkg::OpFold;
          state_d = StIdle;
        end
      end
      StEmit: begin
        cmd_o.op = mva_pkg::OpEmit;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (entry_q == 4'd8) begin
            cmd_o.op = mva_pkg::OpClrTot;
            state_d = StIdle;
          end else begin
            entry_d = entry_q + 4'd1;
            state_d = StEmit;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      slot_q <= '0; axis_q <= '0; entry_q <= '0;
      corr_q <= 1'b0; sec_q <= 1'b0; divst_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q <= slot_d; axis_q <= axis_d; entry_q <= entry_d;
      corr_q <= corr_d; sec_q <= sec_d; divst_q <= divst_d;
    end
  end
endmodule

// ===== rtl/core/molecular_virial_accumulator_unit.sv =====
// top level of the molecular virial accumulator: controller plus datapath
// atom request: twelve 64x64 products on one 32x32 multiplier, plus one accumulate
//   per slot and sum; the last atom of a molecule adds six 128-bit correction divides
//   unless the molecule mass is zero
// load request stores one base entry if the index is below nine; finish request gives nine results
// throughput: one request at a time, set by the shared multiplier and the bit-serial divider
// reset: asynchronous active low, clears all sums, totals and base entries to zero
module molecular_virial_accumulator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [63:0] grad_x_i,
  input  logic signed [63:0] grad_y_i,
  input  logic signed [63:0] grad_z_i,
  input  logic signed [63:0] pos_x_i,
  input  logic signed [63:0] pos_y_i,
  input  logic signed [63:0] pos_z_i,
  input  logic [62:0]        atom_mass_i,
  input  logic [62:0]        mol_mass_i,
  input  logic               end_of_molecule_i,
  input  logic [3:0]         vir_index_i,
  input  logic signed [63:0] vir_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         tensor_index_o,
  output logic signed [63:0] virial_value_o,
  output logic               last_o
);
  mva_pkg::cmd_t  cmd;
  mva_pkg::stat_t stat;
  logic           mul_done;

  // controller walks the slot sequence, one request at a time
  mva_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .mul_done_i(mul_done), .cmd_o(cmd)
  );

  // datapath holds all accumulators and the output register
  mva_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .mul_done_o(mul_done),
    .kind_i, .grad_x_i, .grad_y_i, .grad_z_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .atom_mass_i, .mol_mass_i, .end_of_molecule_i, .vir_index_i, .vir_value_i,
    .tensor_index_o, .virial_value_o, .last_o
  );

  // no new request while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("request taken while results pending");

  // the final entry carries the last flag and index eight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (tensor_index_o == 4'd8))
    else $error("last flag on wrong entry");

  // after the final entry is taken the unit is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("unit not idle after finish");
endmodule
